### sv/cssp_pkg.sv
// Package for the CAN signal scale-and-pack block.
// Holds frame kind codes, register indexes and the constant reciprocal divider.
// No dependencies.
package cssp_pkg;

  // Frame kind carried by each transaction.
  typedef enum logic [1:0] {
    OP_VEHICLE = 2'd0,
    OP_THERMAL = 2'd1,
    OP_POWER   = 2'd2,
    OP_UNUSED  = 2'd3
  } opcode_t;

  // Configuration register indexes (word address = paddr[3:2]).
  typedef enum logic [1:0] {
    REG_VEHICLE_ID = 2'd0,
    REG_THERMAL_ID = 2'd1,
    REG_POWER_ID   = 2'd2,
    REG_NONE       = 2'd3
  } reg_idx_t;

  // Identifier reset values.
  localparam logic [10:0] VEHICLE_ID_RST = 11'h100;
  localparam logic [10:0] THERMAL_ID_RST = 11'h101;
  localparam logic [10:0] POWER_ID_RST   = 11'h102;

  // Reciprocal divide: floor(x / d) = (x * ceil(2^27 / d)) >> 27, exact for x < 2^20
  // because ceil(2^27/d)*d - 2^27 < d <= 2^7.
  localparam int unsigned RECIP_SHIFT = 27;
  localparam logic [23:0] RECIP_DIV10  = 24'd13421773;
  localparam logic [23:0] RECIP_DIV50  = 24'd2684355;
  localparam logic [23:0] RECIP_DIV100 = 24'd1342178;

  function automatic logic [15:0] recip_div(input logic [19:0] x, input logic [23:0] m);
    logic [43:0] prod;
    prod = {24'd0, x} * {20'd0, m};
    return prod[RECIP_SHIFT +: 16];
  endfunction

endpackage

### sv/can_signal_scale_and_pack.sv
// CAN signal scale-and-pack block: one request in, one frame (id + 8-byte payload) out.
// A request is taken every cycle (busy stays low); its frame appears on out_valid
// after passing through the input register, then through the scale, clamp and pack
// logic into the result register. The receiver cannot stall, and none is needed.
// Kind 3 yields frame id 0 with an all-zero payload. Depends on cssp_pkg.
module can_signal_scale_and_pack (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_opcode,
  input  logic signed [23:0] in_value_a,
  input  logic signed [23:0] in_value_b,
  // frame channel
  output logic        out_valid,
  output logic [10:0] out_frame_id,
  output logic [63:0] out_payload,
  // APB-style configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Identifier registers
  logic [10:0] vehicle_id_r, thermal_id_r, power_id_r;
  logic        cfg_wr;
  cssp_pkg::reg_idx_t cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = cssp_pkg::reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vehicle_id_r <= cssp_pkg::VEHICLE_ID_RST;
      thermal_id_r <= cssp_pkg::THERMAL_ID_RST;
      power_id_r   <= cssp_pkg::POWER_ID_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        cssp_pkg::REG_VEHICLE_ID: vehicle_id_r <= pwdata[10:0];
        cssp_pkg::REG_THERMAL_ID: thermal_id_r <= pwdata[10:0];
        cssp_pkg::REG_POWER_ID:   power_id_r   <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  // Register read-back
  always_comb begin
    unique case (cfg_idx)
      cssp_pkg::REG_VEHICLE_ID: prdata = {21'd0, vehicle_id_r};
      cssp_pkg::REG_THERMAL_ID: prdata = {21'd0, thermal_id_r};
      cssp_pkg::REG_POWER_ID:   prdata = {21'd0, power_id_r};
      default:                  prdata = 32'd0;
    endcase
  end

  // Input register
  logic               in_v_r;
  cssp_pkg::opcode_t  op_r;
  logic signed [23:0] a_r, b_r;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= start & ~busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      op_r <= cssp_pkg::opcode_t'(in_opcode);
      a_r  <= in_value_a;
      b_r  <= in_value_b;
    end
  end

  // Signal scaling: clamp, then round half up inside the range
  logic signed [24:0] a_ext, b_ext, a_off, b_off;
  logic [15:0] speed_code, rpm_raw, cool_raw, fuel_code, batt_raw, amb_raw;
  logic [19:0] rpm_x, cool_x, fuel_x, amb_x;

  assign a_ext = {a_r[23], a_r};
  assign b_ext = {b_r[23], b_r};
  assign a_off = a_ext + 25'sd4000;
  assign b_off = b_ext + 25'sd4000;

  // In-range operands plus half the divisor; all stay below 2^20
  assign rpm_x  = b_ext[19:0] + 20'd50;
  assign cool_x = a_off[19:0] + 20'd5;
  assign fuel_x = b_ext[19:0] + 20'd25;
  assign amb_x  = b_off[19:0] + 20'd50;

  always_comb begin
    // speed: factor 1, 0..12000
    if (a_ext <= 25'sd0)          speed_code = 16'd0;
    else if (a_ext >= 25'sd12000) speed_code = 16'd12000;
    else                          speed_code = a_ext[15:0];
    // rpm: factor 1.00, 800..5000
    if (b_ext <= 25'sd80000)       rpm_raw = 16'd800;
    else if (b_ext >= 25'sd500000) rpm_raw = 16'd5000;
    else                           rpm_raw = cssp_pkg::recip_div(rpm_x, cssp_pkg::RECIP_DIV100);
    // coolant: factor 0.1, offset -40, 0..1600
    if (a_off <= 25'sd0)          cool_raw = 16'd0;
    else if (a_off >= 25'sd16000) cool_raw = 16'd1600;
    else                          cool_raw = cssp_pkg::recip_div(cool_x, cssp_pkg::RECIP_DIV10);
    // fuel: factor 0.5, 0..200
    if (b_ext <= 25'sd0)          fuel_code = 16'd0;
    else if (b_ext >= 25'sd10000) fuel_code = 16'd200;
    else                          fuel_code = cssp_pkg::recip_div(fuel_x, cssp_pkg::RECIP_DIV50);
    // battery: factor 0.01, 1100..1500
    if (a_ext <= 25'sd1100)       batt_raw = 16'd1100;
    else if (a_ext >= 25'sd1500)  batt_raw = 16'd1500;
    else                          batt_raw = a_ext[15:0];
    // ambient: factor 1, offset -40, 0..140
    if (b_off <= 25'sd0)          amb_raw = 16'd0;
    else if (b_off >= 25'sd14000) amb_raw = 16'd140;
    else                          amb_raw = cssp_pkg::recip_div(amb_x, cssp_pkg::RECIP_DIV100);
  end

  // Intel-order packing into a zeroed payload
  logic [10:0] id_nxt;
  logic [63:0] payload_nxt;

  always_comb begin
    id_nxt      = 11'd0;
    payload_nxt = 64'd0;
    unique case (op_r)
      cssp_pkg::OP_VEHICLE: begin
        id_nxt             = vehicle_id_r;
        payload_nxt[15:0]  = speed_code;
        payload_nxt[31:16] = rpm_raw;
      end
      cssp_pkg::OP_THERMAL: begin
        id_nxt             = thermal_id_r;
        payload_nxt[42:32] = cool_raw[10:0];
        payload_nxt[55:48] = fuel_code[7:0];
      end
      cssp_pkg::OP_POWER: begin
        id_nxt             = power_id_r;
        payload_nxt[11:0]  = batt_raw[11:0];
        payload_nxt[31:24] = amb_raw[7:0];
      end
      default: ;
    endcase
  end

  // Result register
  logic        out_valid_r;
  logic [10:0] out_frame_id_r;
  logic [63:0] out_payload_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= in_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_v_r) begin
      out_frame_id_r <= id_nxt;
      out_payload_r  <= payload_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_frame_id = out_frame_id_r;
  assign out_payload  = out_payload_r;

endmodule

### sv/cssp_chk.sv
// Port-level checker for can_signal_scale_and_pack, bound to the top level.
// Depends on cssp_pkg for the frame kind codes.
module cssp_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic [1:0]  in_opcode,
  input logic        out_valid,
  input logic [10:0] out_frame_id,
  input logic [63:0] out_payload
);

  // Every accepted transaction gives a frame on out_valid
  a_resp: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_valid)
    else $error("accepted request produced no frame");

  // No frame without a matching request
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 2))
    else $error("frame without request");

  // Undefined kind gives an empty frame
  a_unused_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(in_opcode == cssp_pkg::OP_UNUSED, 2))
      |-> (out_frame_id == 11'd0 && out_payload == 64'd0))
    else $error("undefined kind produced data");

  // Vehicle and power frames only use the low four bytes
  a_low_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && ($past(in_opcode == cssp_pkg::OP_VEHICLE, 2) ||
                   $past(in_opcode == cssp_pkg::OP_POWER, 2)))
      |-> (out_payload[63:32] == 32'd0))
    else $error("signal bits outside their layout");

endmodule

bind can_signal_scale_and_pack cssp_chk u_cssp_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .start        (start),
  .busy         (busy),
  .in_opcode    (in_opcode),
  .out_valid    (out_valid),
  .out_frame_id (out_frame_id),
  .out_payload  (out_payload)
);
